>>> src/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and codes for the indexed min-heap unit.
// ----------------------------------------------------------------------------
package imh_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_NOT_LOWER = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_RD,
    S_DEC_CHK,
    S_EXT_RD,
    S_EXT_MOVE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_CMPR,
    S_DONE
  } state_t;

  localparam int KEY_W  = 6;
  localparam int PRIO_W = 32;

endpackage

>>> src/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/indexed_min_heap_unit.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_unit
// Binary min-heap of key and priority pairs with a key-to-slot table.
// ----------------------------------------------------------------------------
//  channel  | valid     | stall     | payload
//  request  | in_valid  | in_stall  | cmd, key, priority_req
//  result   | out_valid | out_stall | out_key, out_priority, status,
//           |           |           | entry_count, heap_empty
//
// One request is handled at a time; one rejected at acceptance, or a no-op,
// goes straight from the idle to the done state. A sift level passes S_UP_RD
// and S_UP_CMP going up and S_DN_RD, S_DN_RDR, S_DN_CMP and S_DN_CMPR going
// down, set by the one read port of the slot memory. Reset clears the
// presence bits and the count at once. A new request is taken only once the
// previous result leaves, at the earliest in the cycle in which it does.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit #(
  parameter int CAPACITY  = 64,
  parameter int KEY_SPACE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [imh_pkg::KEY_W-1:0] key,
  input  logic signed [31:0]        priority_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [imh_pkg::KEY_W-1:0] out_key,
  output logic signed [31:0]        out_priority,
  output logic [2:0]                status,
  output logic [6:0]                entry_count,
  output logic                      heap_empty
);

  localparam int SW = $clog2(CAPACITY);
  localparam int KW = $clog2(KEY_SPACE);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = imh_pkg::KEY_W + 32;

  imh_pkg::state_t state, state_next;

  logic [KEY_SPACE-1:0] present;
  logic [CW-1:0]        fill;
  logic signed [31:0]   prio_r;
  logic [SW-1:0]        pos;
  logic [SW-1:0]        best;
  logic signed [31:0]   cur_p;
  logic [imh_pkg::KEY_W-1:0] cur_k;
  logic signed [31:0]   best_p;
  logic [imh_pkg::KEY_W-1:0] best_k;
  logic                 res_pend;

  logic          s_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [EW-1:0] s_wd, s_rd;
  logic          k_we;
  logic [KW-1:0] k_wa, k_ra;
  logic [SW-1:0] k_wd, k_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  imh_ram #(.WIDTH(SW), .DEPTH(KEY_SPACE)) u_pos (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );

  logic [imh_pkg::KEY_W-1:0] rd_k;
  logic signed [31:0]        rd_p;
  assign rd_k = s_rd[EW-1:32];
  assign rd_p = s_rd[31:0];

  logic          in_space;
  logic          key_pres;
  logic [KW-1:0] key_idx;
  logic [SW+1:0] lchild, rchild;
  logic [SW-1:0] parent;
  assign key_idx  = KW'(key);
  assign in_space = ({{(32-imh_pkg::KEY_W){1'b0}}, key} < 32'(KEY_SPACE));
  assign key_pres = in_space && present[key_idx];
  assign lchild   = {1'b0, pos, 1'b1};
  assign rchild   = {1'b0, pos, 1'b0} + (SW+2)'(2);
  assign parent   = (pos - SW'(1)) >> 1;

  logic accept;
  assign in_stall = (state != imh_pkg::S_IDLE) || (res_pend && out_stall);
  assign accept   = in_valid && !in_stall;

  logic finish;
  assign finish = (state == imh_pkg::S_DONE);

  logic l_valid;
  logic r_valid;
  logic r_better;
  assign l_valid  = (lchild < (SW+2)'(fill));
  assign r_valid  = (rchild < (SW+2)'(fill));
  assign r_better = r_valid && (rd_p < best_p);

  always_comb begin
    state_next = state;
    case (state)
      imh_pkg::S_IDLE: begin
        if (accept) begin
          state_next = imh_pkg::S_DONE;
          case (imh_pkg::cmd_t'(cmd))
            imh_pkg::CMD_INSERT:
              if (in_space && !key_pres && fill < CW'(CAPACITY)) begin
                state_next = imh_pkg::S_UP_RD;
              end
            imh_pkg::CMD_EXTRACT:
              if (fill != '0) begin
                state_next = imh_pkg::S_EXT_RD;
              end
            imh_pkg::CMD_DECREASE:
              if (key_pres) begin
                state_next = imh_pkg::S_DEC_RD;
              end
            default: state_next = imh_pkg::S_DONE;
          endcase
        end
      end
      imh_pkg::S_DEC_RD:  state_next = imh_pkg::S_DEC_CHK;
      imh_pkg::S_DEC_CHK: state_next = (prio_r < rd_p) ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
      imh_pkg::S_EXT_RD:  state_next = imh_pkg::S_EXT_MOVE;
      imh_pkg::S_EXT_MOVE: state_next = (fill != '0) ? imh_pkg::S_DN_RD : imh_pkg::S_DONE;
      imh_pkg::S_UP_RD:   state_next = (pos == '0) ? imh_pkg::S_DONE : imh_pkg::S_UP_CMP;
      imh_pkg::S_UP_CMP:  state_next = (cur_p < rd_p) ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
      imh_pkg::S_DN_RD:   state_next = l_valid ? imh_pkg::S_DN_RDR : imh_pkg::S_DONE;
      imh_pkg::S_DN_RDR:  state_next = imh_pkg::S_DN_CMP;
      imh_pkg::S_DN_CMP:  state_next = imh_pkg::S_DN_CMPR;
      imh_pkg::S_DN_CMPR: state_next = (best != pos || r_better)
                                       ? imh_pkg::S_DN_RD : imh_pkg::S_DONE;
      imh_pkg::S_DONE:    state_next = imh_pkg::S_IDLE;
      default:            state_next = imh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_we = 1'b0;
    s_wa = pos;
    s_wd = {cur_k, cur_p};
    s_ra = pos;
    k_we = 1'b0;
    k_wa = KW'(cur_k);
    k_wd = pos;
    k_ra = key_idx;
    case (state)
      imh_pkg::S_IDLE: begin
        s_ra = '0;
        k_ra = key_idx;
      end
      imh_pkg::S_DEC_RD: s_ra = k_rd;
      imh_pkg::S_EXT_RD: s_ra = SW'(fill - CW'(1));
      imh_pkg::S_UP_RD: begin
        s_ra = parent;
        s_we = 1'b1;
        k_we = 1'b1;
      end
      imh_pkg::S_UP_CMP: begin
        if (cur_p < rd_p) begin
          s_we = 1'b1;
          s_wa = pos;
          s_wd = s_rd;
          k_we = 1'b1;
          k_wa = KW'(rd_k);
          k_wd = pos;
        end
      end
      imh_pkg::S_DN_RD: begin
        s_ra = lchild[SW-1:0];
        s_we = 1'b1;
        k_we = 1'b1;
      end
      imh_pkg::S_DN_CMP: s_ra = rchild[SW-1:0];
      imh_pkg::S_DN_CMPR: begin
        if (best != pos || r_better) begin
          s_we = 1'b1;
          s_wa = pos;
          s_wd = r_better ? s_rd : {best_k, best_p};
          k_we = 1'b1;
          k_wa = r_better ? KW'(rd_k) : KW'(best_k);
          k_wd = pos;
        end
      end
      default: s_ra = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= imh_pkg::S_IDLE;
      present  <= '0;
      fill     <= '0;
      res_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid   <= 1'b1;
        res_pend    <= 1'b1;
        entry_count <= 7'(fill);
        heap_empty  <= (fill == '0);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        res_pend  <= 1'b0;
      end
      case (state)
        imh_pkg::S_IDLE: begin
          if (accept) begin
            prio_r       <= priority_req;
            out_key      <= '0;
            out_priority <= '0;
            cur_k        <= key;
            cur_p        <= priority_req;
            pos          <= SW'(fill);
            case (imh_pkg::cmd_t'(cmd))
              imh_pkg::CMD_INSERT: begin
                if (!in_space) begin
                  status <= imh_pkg::ST_ABSENT;
                end else if (key_pres) begin
                  status <= imh_pkg::ST_DUPLICATE;
                end else if (fill >= CW'(CAPACITY)) begin
                  status <= imh_pkg::ST_FULL;
                end else begin
                  status <= imh_pkg::ST_OK;
                  present[key_idx] <= 1'b1;
                  fill <= fill + CW'(1);
                end
              end
              imh_pkg::CMD_EXTRACT: begin
                if (fill == '0) begin
                  status <= imh_pkg::ST_EMPTY;
                end else begin
                  status <= imh_pkg::ST_OK;
                end
              end
              imh_pkg::CMD_DECREASE: begin
                if (!key_pres) begin
                  status <= imh_pkg::ST_ABSENT;
                end else begin
                  status <= imh_pkg::ST_OK;
                end
              end
              default: status <= imh_pkg::ST_OK;
            endcase
          end
        end
        imh_pkg::S_DEC_RD: pos <= k_rd;
        imh_pkg::S_DEC_CHK: begin
          if (!(prio_r < rd_p)) begin
            status <= imh_pkg::ST_NOT_LOWER;
          end
          cur_k <= rd_k;
        end
        imh_pkg::S_EXT_RD: begin
          out_key      <= rd_k;
          out_priority <= rd_p;
          present[KW'(rd_k)] <= 1'b0;
          fill <= fill - CW'(1);
        end
        imh_pkg::S_EXT_MOVE: begin
          cur_k <= rd_k;
          cur_p <= rd_p;
          pos   <= '0;
        end
        imh_pkg::S_UP_CMP: begin
          if (cur_p < rd_p) begin
            pos <= parent;
          end
        end
        imh_pkg::S_DN_RD: begin
          best   <= pos;
          best_k <= cur_k;
          best_p <= cur_p;
        end
        imh_pkg::S_DN_RDR: begin
          if (rd_p < cur_p) begin
            best   <= lchild[SW-1:0];
            best_k <= rd_k;
            best_p <= rd_p;
          end
        end
        imh_pkg::S_DN_CMPR: begin
          if (r_better) begin
            pos <= rchild[SW-1:0];
          end else if (best != pos) begin
            pos <= best;
          end
        end
        default: pos <= pos;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= CW'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != imh_pkg::S_IDLE)
    else $error("request accepted without starting work");
  assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished request produced no result");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heap_empty == (entry_count == 7'd0)))
    else $error("empty flag disagrees with count");

endmodule
